FILE: hdl/rmps_pkg.sv
// rmps_pkg: sizes, codes and constants of the rotating, mirroring palette scan-out
// used by the channel interfaces and by rotated_mirrored_palette_scanout
package rmps_pkg;

  localparam int SRC_WIDTH     = 160;
  localparam int SRC_HEIGHT    = 144;
  localparam int CANVAS_WIDTH  = 320;
  localparam int CANVAS_HEIGHT = 240;

  localparam int DEPTH   = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COORD_W = 8;
  localparam int CAN_W   = 11;

  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int CODE_W   = 6;
  localparam int COLOUR_W = 16;
  localparam int PAL_W    = 64;
  localparam int CFG_IDX_W = 3;

  // centring offsets, upright and quarter-turned picture
  localparam int X0_UP  = (SRC_WIDTH  <= CANVAS_WIDTH)  ? (CANVAS_WIDTH  - SRC_WIDTH)  / 2 : 0;
  localparam int Y0_UP  = (SRC_HEIGHT <= CANVAS_HEIGHT) ? (CANVAS_HEIGHT - SRC_HEIGHT) / 2 : 0;
  localparam int X0_ROT = (SRC_HEIGHT <= CANVAS_WIDTH)  ? (CANVAS_WIDTH  - SRC_HEIGHT) / 2 : 0;
  localparam int Y0_ROT = (SRC_WIDTH  <= CANVAS_HEIGHT) ? (CANVAS_HEIGHT - SRC_WIDTH)  / 2 : 0;

  localparam logic [PAL_W-1:0]    PALETTE_RESET = 64'h0000_52AA_AD55_FFFF;
  localparam logic [COLOUR_W-1:0] BLACK         = 16'h0000;

  localparam int LAYER_COUNT = 3;
  localparam int SHADE_COUNT = 4;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [1:0] ROT_UP   = 2'd0;
  localparam logic [1:0] ROT_CCW  = 2'd1;
  localparam logic [1:0] ROT_HALF = 2'd2;
  localparam logic [1:0] ROT_CW   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PAL0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR   = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CODE_W-1:0]  code_t;

endpackage

FILE: hdl/rmps_if.sv
// rmps_in_if and rmps_out_if: valid/ready channels for command words and colour words
// depends on rmps_pkg
interface rmps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [rmps_pkg::COL_W-1:0]           col;
  logic [rmps_pkg::ROW_W-1:0]           row;
  logic [rmps_pkg::CODE_W-1:0]          pixel_code;

  modport source (output valid, command, col, row, pixel_code, input ready);
  modport sink   (input valid, command, col, row, pixel_code, output ready);
endinterface

interface rmps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rmps_pkg::COLOUR_W-1:0]        colour;
  logic                                 is_border;

  modport source (output valid, colour, is_border, input ready);
  modport sink   (input valid, colour, is_border, output ready);
endinterface

FILE: hdl/rotated_mirrored_palette_scanout.sv
// rotated_mirrored_palette_scanout: frame store with mirrored, rotated, centred palette scan-out
// depends on rmps_pkg and the channel interfaces in rmps_if.sv
//
// One command word is taken every cycle while the pipeline advances. A store word writes
// one 6-bit code into the 160x144 frame store and gives no result; a render word gives one
// colour word through the address-stage registers, the frame-store read and the palette
// stage, and a new word follows in every cycle while the result side takes words. The frame
// store is a single-port synchronous memory: each cycle the address stage either writes one
// entry or reads one, in command order, so a render always sees every earlier store. When the
// output word is not taken the whole pipeline holds. The frame store is not cleared;
// rendering an entry that was never written gives an undefined colour.
module rotated_mirrored_palette_scanout (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rmps_in_if.sink                               in_ch,
  rmps_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [rmps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmps_pkg::PAL_W-1:0]            cfg_wdata
);

  localparam int CW = rmps_pkg::CAN_W;

  // configuration
  logic [rmps_pkg::PAL_W-1:0] pal_r [rmps_pkg::LAYER_COUNT];
  logic [1:0]                 rotation_r;
  logic                       mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rmps_pkg::LAYER_COUNT; i++) pal_r[i] <= rmps_pkg::PALETTE_RESET;
      rotation_r <= rmps_pkg::ROT_UP;
      mirror_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmps_pkg::REG_PAL0:     pal_r[0]   <= cfg_wdata;
        rmps_pkg::REG_PAL1:     pal_r[1]   <= cfg_wdata;
        rmps_pkg::REG_PAL2:     pal_r[2]   <= cfg_wdata;
        rmps_pkg::REG_ROTATION: rotation_r <= cfg_wdata[1:0];
        rmps_pkg::REG_MIRROR:   mirror_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // address stage, combinational part
  logic [CW-1:0]          col_w, row_w, x0, y0, w_c, h_c, u_full, v_full;
  logic                   in_pic;
  rmps_pkg::coord_t       wm1, u, v, uu, sx, sy;
  rmps_pkg::addr_t        rd_addr, wr_addr;
  logic                   st_ok;

  always_comb begin
    col_w = CW'(in_ch.col);
    row_w = CW'(in_ch.row);
    if (rotation_r[0]) begin
      w_c = CW'(rmps_pkg::SRC_HEIGHT);
      h_c = CW'(rmps_pkg::SRC_WIDTH);
      x0  = CW'(rmps_pkg::X0_ROT);
      y0  = CW'(rmps_pkg::Y0_ROT);
    end else begin
      w_c = CW'(rmps_pkg::SRC_WIDTH);
      h_c = CW'(rmps_pkg::SRC_HEIGHT);
      x0  = CW'(rmps_pkg::X0_UP);
      y0  = CW'(rmps_pkg::Y0_UP);
    end
    in_pic = (col_w >= x0) && (col_w < x0 + w_c) && (col_w < CW'(rmps_pkg::CANVAS_WIDTH)) &&
             (row_w >= y0) && (row_w < y0 + h_c) && (row_w < CW'(rmps_pkg::CANVAS_HEIGHT));
    u_full = col_w - x0;
    v_full = row_w - y0;
    u      = u_full[rmps_pkg::COORD_W-1:0];
    v      = v_full[rmps_pkg::COORD_W-1:0];
    wm1    = rmps_pkg::COORD_W'(w_c - CW'(1));
    uu     = mirror_r ? (wm1 - u) : u;
    unique case (rotation_r)
      rmps_pkg::ROT_UP: begin
        sx = uu;
        sy = v;
      end
      rmps_pkg::ROT_CCW: begin
        sx = rmps_pkg::COORD_W'(rmps_pkg::SRC_WIDTH - 1) - v;
        sy = uu;
      end
      rmps_pkg::ROT_HALF: begin
        sx = rmps_pkg::COORD_W'(rmps_pkg::SRC_WIDTH - 1) - uu;
        sy = rmps_pkg::COORD_W'(rmps_pkg::SRC_HEIGHT - 1) - v;
      end
      default: begin
        sx = v;
        sy = rmps_pkg::COORD_W'(rmps_pkg::SRC_HEIGHT - 1) - uu;
      end
    endcase
    rd_addr = rmps_pkg::ADDR_W'(32'(sy) * 32'(rmps_pkg::SRC_WIDTH) + 32'(sx));
    st_ok   = (col_w < CW'(rmps_pkg::SRC_WIDTH)) && (row_w < CW'(rmps_pkg::SRC_HEIGHT));
    wr_addr = rmps_pkg::ADDR_W'(32'(in_ch.row) * 32'(rmps_pkg::SRC_WIDTH) +
                                32'(in_ch.col));
  end

  // address stage registers
  logic             s1_valid_r, s1_render_r, s1_border_r, s1_wen_r;
  rmps_pkg::addr_t  s1_addr_r;
  rmps_pkg::code_t  s1_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_render_r <= (in_ch.command == rmps_pkg::CMD_RENDER);
      s1_border_r <= !in_pic;
      s1_wen_r    <= (in_ch.command == rmps_pkg::CMD_STORE) && st_ok;
      s1_addr_r   <= (in_ch.command == rmps_pkg::CMD_STORE) ? wr_addr : rd_addr;
      s1_code_r   <= in_ch.pixel_code;
    end
  end

  // frame store, one access per cycle while the pipeline advances
  rmps_pkg::code_t frame_mem [rmps_pkg::DEPTH];
  rmps_pkg::code_t s2_code_r;
  logic            s2_valid_r, s2_border_r;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      if (!s1_render_r && s1_wen_r) frame_mem[s1_addr_r] <= s1_code_r;
      if (s1_render_r) s2_code_r <= frame_mem[s1_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_render_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s2_border_r <= s1_border_r;
  end

  // palette stage
  logic [1:0]                    layer;
  logic [3:0]                    shade;
  logic [rmps_pkg::COLOUR_W-1:0] colour_nxt, colour_r;
  logic                          border_r;

  always_comb begin
    layer      = s2_code_r[5:4];
    shade      = s2_code_r[3:0];
    colour_nxt = rmps_pkg::BLACK;
    if (!s2_border_r && (32'(layer) < rmps_pkg::LAYER_COUNT) &&
        (32'(shade) < rmps_pkg::SHADE_COUNT)) begin
      colour_nxt = pal_r[layer[1:0]][16*shade[1:0] +: rmps_pkg::COLOUR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      colour_r <= colour_nxt;
      border_r <= s2_border_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.colour    = colour_r;
  assign out_ch.is_border = border_r;

`ifndef ASSERT_OFF
  a_border_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && border_r) |-> (colour_r == rmps_pkg::BLACK))
    else $error("border word with non-black colour");

  a_store_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && !s1_render_r) |=> !s2_valid_r)
    else $error("store word produced a result");

  // border renders read an arbitrary entry, so only picture codes must hold
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s2_valid_r) |=> (s2_valid_r && $stable(s2_border_r) &&
                              (s2_border_r || $stable(s2_code_r))))
    else $error("read stage changed while stalled");

  a_word_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r))
    else $error("result word without a render in the read stage");
`endif

endmodule
